// ----- rtl/trfa_pkg.sv -----
`default_nettype none

package trfa_pkg;

	localparam int unsigned SLOT_ID_W = 4;
	localparam int unsigned COORD_W   = 16;
	localparam int unsigned EXTENT_W  = 11;
	localparam int unsigned CNT_W     = 8;

	localparam logic [7:0] CFG_X_EXTENT = 8'd0;
	localparam logic [7:0] CFG_Y_EXTENT = 8'd1;

	localparam logic [EXTENT_W-1:0] X_EXTENT_RST = 11'd800;
	localparam logic [EXTENT_W-1:0] Y_EXTENT_RST = 11'd480;

	localparam logic [7:0] ID_FIRST = 8'd2;
	localparam logic [7:0] ID_LAST  = 8'd11;
	localparam int unsigned REL_BIT = 5;

	typedef enum logic [1:0] {
		KIND_CONTACT   = 2'd0,
		KIND_LIFT      = 2'd1,
		KIND_END_TOUCH = 2'd2,
		KIND_END_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_WALK,
		ST_FEND,
		ST_APPLY
	} state_t;

	// decoded report as it travels from the front to the back
	typedef struct packed {
		logic [SLOT_ID_W-1:0] slot;
		logic                 rel;
		logic [COORD_W-1:0]   x;
		logic [COORD_W-1:0]   y;
	} item_t;

endpackage

`default_nettype wire

// ----- rtl/trfa_front.sv -----
`default_nettype none

module trfa_front import trfa_pkg::*; #(
	parameter int unsigned SLOTS = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_index,
	input  wire logic [EXTENT_W-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          report_id,
	input  wire logic [7:0]          status_byte,
	input  wire logic [7:0]          x_high,
	input  wire logic [7:0]          y_high,
	input  wire logic [7:0]          low_bits,
	input  wire logic                q_full,
	output logic                     push,
	output item_t                    push_item
);

	logic [EXTENT_W-1:0] x_extent_q;
	logic [EXTENT_W-1:0] y_extent_q;
	logic [7:0]          id_m2;
	logic                id_ok;
	logic [9:0]          raw_x;
	logic [9:0]          raw_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_extent_q <= X_EXTENT_RST;
			y_extent_q <= Y_EXTENT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_X_EXTENT) begin
				x_extent_q <= cfg_data;
			end
			if (cfg_index == CFG_Y_EXTENT) begin
				y_extent_q <= cfg_data;
			end
		end
	end

	assign id_m2 = report_id - ID_FIRST;
	assign id_ok = (report_id >= ID_FIRST) && (report_id <= ID_LAST) && (id_m2 < 8'(SLOTS));

	assign raw_x = {x_high, low_bits[7:6]};
	assign raw_y = {y_high, low_bits[3:2]};

	// out-of-range ids are swallowed here and never reach the queue
	assign in_stall = q_full;
	assign push     = in_valid && !q_full && id_ok;

	always_comb begin
		push_item.slot = id_m2[SLOT_ID_W-1:0];
		push_item.rel  = status_byte[REL_BIT];
		push_item.x    = {5'd0, x_extent_q} - {6'd0, raw_x};
		push_item.y    = {5'd0, y_extent_q} - {6'd0, raw_y};
	end

endmodule

`default_nettype wire

// ----- rtl/trfa_queue.sv -----
`default_nettype none

module trfa_queue import trfa_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output item_t      head
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/trfa_back.sv -----
`default_nettype none

module trfa_back import trfa_pkg::*; #(
	parameter int unsigned SLOTS = 5
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	input  wire item_t q_head,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [1:0] record_kind,
	output logic [2:0] slot_index,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic       last
);

	localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);

	state_t state_q, state_d;

	item_t              cur_q;
	logic [SLOT_W-1:0]  cur_slot;
	logic [SLOT_W-1:0]  idx_q;
	logic               second_q;
	logic               first_vld_q;
	logic [COORD_W-1:0] first_x_q;
	logic [COORD_W-1:0] first_y_q;

	logic [SLOTS-1:0]   pmark_q;
	logic [SLOTS-1:0]   prel_q;
	logic [COORD_W-1:0] px_q [SLOTS];
	logic [COORD_W-1:0] py_q [SLOTS];
	logic [CNT_W-1:0]   pcnt_q;
	logic [SLOTS-1:0]   srel_q;
	logic [COORD_W-1:0] sx_q [SLOTS];
	logic [COORD_W-1:0] sy_q [SLOTS];
	logic [CNT_W-1:0]   scnt_q;

	logic [SLOTS-1:0]   fill_vec;
	logic               out_valid_q;
	logic               out_free;
	logic               do_fill;
	logic               emit_slot;
	logic               emit_end;
	logic               do_apply;
	logic               start_walk;
	logic               start_second;
	logic               end_last;

	assign cur_slot = cur_q.slot[SLOT_W-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			fill_vec[i] = !pmark_q[i] && !srel_q[i];
		end
	end

	// a release that empties the frame flushes a second time; the first
	// frame end is then not the item's final record
	assign end_last = second_q || !(cur_q.rel && (pcnt_q == 8'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		pop          = 1'b0;
		do_fill      = 1'b0;
		emit_slot    = 1'b0;
		emit_end     = 1'b0;
		do_apply     = 1'b0;
		start_walk   = 1'b0;
		start_second = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (pmark_q[cur_slot]) begin
					do_fill    = $signed(scnt_q) > $signed(pcnt_q);
					start_walk = 1'b1;
					state_d    = ST_WALK;
				end else begin
					state_d = ST_APPLY;
				end
			end
			ST_WALK: begin
				if (!pmark_q[idx_q] || out_free) begin
					emit_slot = pmark_q[idx_q];
					if (idx_q == LAST_IDX) begin
						state_d = ST_FEND;
					end
				end
			end
			ST_FEND: begin
				if (out_free) begin
					emit_end = 1'b1;
					state_d  = second_q ? ST_IDLE : ST_APPLY;
				end
			end
			ST_APPLY: begin
				do_apply = 1'b1;
				if (cur_q.rel && ((scnt_q - 8'd1) == pcnt_q)) begin
					start_walk   = 1'b1;
					start_second = 1'b1;
					state_d      = ST_WALK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// walk bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			second_q    <= 1'b0;
			first_vld_q <= 1'b0;
		end else begin
			if (start_walk) begin
				idx_q       <= '0;
				second_q    <= start_second;
				first_vld_q <= 1'b0;
			end else if (state_q == ST_WALK && state_d != state_q) begin
				idx_q <= '0;
			end else if (state_q == ST_WALK && (!pmark_q[idx_q] || out_free)) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
			if (emit_slot && !prel_q[idx_q] && !first_vld_q) begin
				first_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		if (emit_slot && !prel_q[idx_q] && !first_vld_q) begin
			first_x_q <= px_q[idx_q];
			first_y_q <= py_q[idx_q];
		end
	end

	// pending and sent frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmark_q <= '0;
			prel_q  <= '1;
			pcnt_q  <= '0;
			srel_q  <= '1;
			scnt_q  <= '0;
		end else begin
			if (do_fill) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (fill_vec[i]) begin
						pmark_q[i] <= 1'b1;
						prel_q[i]  <= srel_q[i];
					end
				end
				pcnt_q <= pcnt_q + CNT_W'($countones(fill_vec));
			end
			if (emit_end) begin
				srel_q  <= prel_q;
				scnt_q  <= pcnt_q;
				pmark_q <= '0;
				prel_q  <= '1;
				pcnt_q  <= '0;
			end
			if (do_apply) begin
				prel_q[cur_slot] <= cur_q.rel;
				if (cur_q.rel) begin
					scnt_q <= scnt_q - 8'd1;
					if ($signed(pcnt_q) < $signed(8'sd1)) begin
						pmark_q[cur_slot] <= 1'b1;
					end
				end else begin
					pcnt_q            <= pcnt_q + 8'd1;
					pmark_q[cur_slot] <= 1'b1;
				end
			end
		end
	end

	// positions only count where the matching status says contact
	always_ff @(posedge clk) begin
		if (do_fill) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (fill_vec[i]) begin
					px_q[i] <= sx_q[i];
					py_q[i] <= sy_q[i];
				end
			end
		end
		if (emit_end) begin
			for (int i = 0; i < SLOTS; i++) begin
				sx_q[i] <= px_q[i];
				sy_q[i] <= py_q[i];
			end
		end
		if (do_apply) begin
			px_q[cur_slot] <= cur_q.x;
			py_q[cur_slot] <= cur_q.y;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_slot || emit_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_slot) begin
			record_kind <= prel_q[idx_q] ? KIND_LIFT : KIND_CONTACT;
			slot_index  <= 3'(idx_q);
			pos_x       <= prel_q[idx_q] ? 16'd0 : px_q[idx_q];
			pos_y       <= prel_q[idx_q] ? 16'd0 : py_q[idx_q];
			last        <= 1'b0;
		end else if (emit_end) begin
			record_kind <= first_vld_q ? KIND_END_TOUCH : KIND_END_NONE;
			slot_index  <= 3'd0;
			pos_x       <= first_vld_q ? first_x_q : 16'd0;
			pos_y       <= first_vld_q ? first_y_q : 16'd0;
			last        <= end_last;
		end
	end

	a_walk_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> idx_q <= LAST_IDX)
		else $error("flush walk index beyond slot count");

	a_commit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_end |=> (pcnt_q == 8'd0) && (pmark_q == '0))
		else $error("pending frame not cleared after frame end");

	// after the final frame end only the state update may remain, never another flush
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		emit_end && end_last |=> !start_walk)
		else $error("final record issued while item still in progress");

	a_second_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK && second_q |-> cur_q.rel)
		else $error("second flush without a release");

endmodule

`default_nettype wire

// ----- rtl/touch_report_frame_assembler.sv -----
// Without a flush, an accepted item is written into the queue, popped in ST_IDLE, checked in
// ST_DECIDE and applied to the frames in ST_APPLY. A flush walks every slot, one per cycle
// while the output is not stalled, then emits the frame end; an item can cause two flushes.
// The input is taken while the two-entry queue has room; results leave from one output register.
// Reset clears both frames and counts and loads x_extent 800, y_extent 480; no clearing pass.
`default_nettype none

module touch_report_frame_assembler import trfa_pkg::*; #(
	parameter int unsigned SLOTS = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [7:0]          cfg_index,
	input  wire logic [EXTENT_W-1:0] cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          report_id,
	input  wire logic [7:0]          status_byte,
	input  wire logic [7:0]          x_high,
	input  wire logic [7:0]          y_high,
	input  wire logic [7:0]          low_bits,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               record_kind,
	output logic [2:0]               slot_index,
	output logic [15:0]              pos_x,
	output logic [15:0]              pos_y,
	output logic                     last
);

	logic  q_full;
	logic  q_empty;
	logic  push;
	logic  pop;
	item_t push_item;
	item_t q_head;

	trfa_front #(.SLOTS(SLOTS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.report_id   (report_id),
		.status_byte (status_byte),
		.x_high      (x_high),
		.y_high      (y_high),
		.low_bits    (low_bits),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	trfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	trfa_back #(.SLOTS(SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.record_kind (record_kind),
		.slot_index  (slot_index),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.last        (last)
	);

endmodule

`default_nettype wire
